### hdl/spi_pkg.sv
// Shared types, widths and constants of the segment pair intersection block.
`default_nettype none

package spi_pkg;

	localparam int COORD_BITS = 16;
	localparam int FRAC_BITS  = 8;
	localparam int CROSS_BITS = 24;

	localparam int DIFF_W = COORD_BITS + 1;
	localparam int PROD_W = 2 * DIFF_W;
	localparam int WIDE_W = PROD_W + 1;
	localparam int HALF_W = PROD_W / 2;
	localparam int MAG_W  = COORD_BITS + PROD_W;
	localparam int QUO_W  = COORD_BITS + FRAC_BITS;
	localparam int RES_W  = COORD_BITS + FRAC_BITS + 2;
	localparam int SAT_W  = (RES_W > CROSS_BITS) ? RES_W : CROSS_BITS;
	localparam int CELLS  = QUO_W;

	localparam logic signed [SAT_W-1:0] CROSS_MAX = SAT_W'((64'sd1 <<< (CROSS_BITS - 1)) - 64'sd1);
	localparam logic signed [SAT_W-1:0] CROSS_MIN = -CROSS_MAX - SAT_W'(1);

	typedef struct packed {
		logic signed [COORD_BITS-1:0] a_start_x;
		logic signed [COORD_BITS-1:0] a_start_y;
		logic signed [COORD_BITS-1:0] a_end_x;
		logic signed [COORD_BITS-1:0] a_end_y;
		logic signed [COORD_BITS-1:0] b_start_x;
		logic signed [COORD_BITS-1:0] b_start_y;
		logic signed [COORD_BITS-1:0] b_end_x;
		logic signed [COORD_BITS-1:0] b_end_y;
	} pair_t;

	typedef struct packed {
		logic                         hit;
		logic                         strict_hit;
		logic                         same_line;
		logic                         overlap;
		logic                         point_valid;
		logic signed [CROSS_BITS-1:0] cross_x;
		logic signed [CROSS_BITS-1:0] cross_y;
	} isect_t;

	// flags and offsets that ride alongside the divider
	typedef struct packed {
		logic                         hit;
		logic                         strict_hit;
		logic                         same_line;
		logic                         overlap;
		logic                         point_valid;
		logic signed [COORD_BITS-1:0] base_x;
		logic signed [COORD_BITS-1:0] base_y;
		logic                         neg_x;
		logic                         neg_y;
	} side_t;

	typedef struct packed {
		side_t             side;
		logic [PROD_W-1:0] den;
		logic [PROD_W-1:0] rem_x;
		logic [QUO_W-1:0]  acc_x;
		logic [PROD_W-1:0] rem_y;
		logic [QUO_W-1:0]  acc_y;
	} cell_t;

endpackage

`default_nettype wire

### hdl/spi_div_cell.sv
// One restoring division step for both axes, registered.
`default_nettype none

module spi_div_cell
	import spi_pkg::*;
(
	input  wire logic  clk,
	input  wire logic  arst_n,
	input  wire logic  en,
	input  wire logic  in_valid,
	input  wire cell_t in_data,
	output logic       out_valid,
	output cell_t      out_data
);

	logic [PROD_W:0] tx;
	logic [PROD_W:0] ty;
	logic            gex;
	logic            gey;
	cell_t           nxt;
	logic            valid_q;
	cell_t           data_q;

	always_comb begin
		tx  = {in_data.rem_x, in_data.acc_x[QUO_W-1]};
		ty  = {in_data.rem_y, in_data.acc_y[QUO_W-1]};
		gex = tx >= {1'b0, in_data.den};
		gey = ty >= {1'b0, in_data.den};
		nxt = in_data;
		// shift the dividend bit out of the top, the quotient bit into the bottom
		nxt.rem_x = gex ? PROD_W'(tx - {1'b0, in_data.den}) : tx[PROD_W-1:0];
		nxt.rem_y = gey ? PROD_W'(ty - {1'b0, in_data.den}) : ty[PROD_W-1:0];
		nxt.acc_x = {in_data.acc_x[QUO_W-2:0], gex};
		nxt.acc_y = {in_data.acc_y[QUO_W-2:0], gey};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (en) begin
			valid_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			data_q <= nxt;
		end
	end

	assign out_valid = valid_q;
	assign out_data  = data_q;

endmodule

`default_nettype wire

### hdl/spi_front.sv
// Differences, cross products, classification and scaled products ahead of the divider.
`default_nettype none

module spi_front
	import spi_pkg::*;
(
	input  wire logic  clk,
	input  wire logic  arst_n,
	input  wire logic  en,
	input  wire logic  in_valid,
	input  wire pair_t in_data,
	output logic       out_valid,
	output cell_t      out_data
);

	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6;

	// stage 1
	logic signed [DIFF_W-1:0]     dax_s1, day_s1, dbx_s1, dby_s1;
	logic signed [DIFF_W-1:0]     ox_s1, oy_s1, ex_s1, ey_s1;
	logic signed [COORD_BITS-1:0] ax0_s1, ay0_s1;
	logic                         shared_s1;
	logic                         shared;
	// stage 2
	logic signed [PROD_W-1:0]     den1_s2, den2_s2, na1_s2, na2_s2, nb1_s2, nb2_s2;
	logic signed [PROD_W-1:0]     sox_s2, soy_s2, sex_s2, sey_s2;
	logic signed [PROD_W-1:0]     sax_s2, say_s2, sbx_s2, sby_s2;
	logic signed [DIFF_W-1:0]     dax_s2, day_s2;
	logic signed [COORD_BITS-1:0] ax0_s2, ay0_s2;
	logic                         shared_s2;
	// stage 3
	logic signed [WIDE_W-1:0]     den_s3, na_s3, nb_s3, d1_s3, d2_s3, la_s3, lb_s3;
	logic signed [DIFF_W-1:0]     dax_s3, day_s3;
	logic signed [COORD_BITS-1:0] ax0_s3, ay0_s3;
	logic                         shared_s3;
	// stage 4
	logic signed [WIDE_W-1:0]     den_a, na_a, nb_a;
	logic signed [DIFF_W-1:0]     dax_a, day_a;
	logic                         den_zero, na_ok, nb_ok, crossing, collinear;
	side_t                        side;
	side_t                        side_s4;
	logic [PROD_W-1:0]            den_s4, na_s4;
	logic [COORD_BITS-1:0]        dxm_s4, dym_s4;
	// stage 5
	side_t                                   side_s5;
	logic [PROD_W-1:0]                       den_s5;
	logic [COORD_BITS+HALF_W-1:0]            px_lo_s5, py_lo_s5;
	logic [COORD_BITS+PROD_W-HALF_W-1:0]     px_hi_s5, py_hi_s5;
	// stage 6
	logic [MAG_W-1:0] magx, magy;
	cell_t            div_in;
	cell_t            cell_s6;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
		end else if (en) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
			v_s6 <= v_s5;
		end
	end

	assign shared =
		(in_data.a_start_x == in_data.b_start_x && in_data.a_start_y == in_data.b_start_y) ||
		(in_data.a_start_x == in_data.b_end_x   && in_data.a_start_y == in_data.b_end_y)   ||
		(in_data.a_end_x   == in_data.b_start_x && in_data.a_end_y   == in_data.b_start_y) ||
		(in_data.a_end_x   == in_data.b_end_x   && in_data.a_end_y   == in_data.b_end_y);

	always_comb begin
		den_zero  = den_s3 == '0;
		den_a     = den_s3[WIDE_W-1] ? -den_s3 : den_s3;
		na_a      = den_s3[WIDE_W-1] ? -na_s3  : na_s3;
		nb_a      = den_s3[WIDE_W-1] ? -nb_s3  : nb_s3;
		na_ok     = !na_a[WIDE_W-1] && (na_a <= den_a);
		nb_ok     = !nb_a[WIDE_W-1] && (nb_a <= den_a);
		crossing  = !den_zero && na_ok && nb_ok;
		collinear = den_zero && (na_s3 == '0) && (nb_s3 == '0);
		dax_a     = dax_s3[DIFF_W-1] ? -dax_s3 : dax_s3;
		day_a     = day_s3[DIFF_W-1] ? -day_s3 : day_s3;

		side.hit         = collinear || crossing;
		side.strict_hit  = collinear || (crossing && !shared_s3);
		side.same_line   = collinear;
		side.overlap     = collinear &&
			(d1_s3 == lb_s3 || d1_s3 == la_s3 || d2_s3 == la_s3 || d2_s3 == lb_s3);
		side.point_valid = crossing;
		side.base_x      = ax0_s3;
		side.base_y      = ay0_s3;
		side.neg_x       = dax_s3[DIFF_W-1];
		side.neg_y       = day_s3[DIFF_W-1];
	end

	always_comb begin
		magx = MAG_W'(px_lo_s5) + (MAG_W'(px_hi_s5) << HALF_W);
		magy = MAG_W'(py_lo_s5) + (MAG_W'(py_hi_s5) << HALF_W);
		div_in.side  = side_s5;
		div_in.den   = den_s5;
		// the high part already lies below the divisor, the low part feeds the steps
		div_in.rem_x = magx[MAG_W-1:COORD_BITS];
		div_in.rem_y = magy[MAG_W-1:COORD_BITS];
		div_in.acc_x = QUO_W'(magx[COORD_BITS-1:0]) << FRAC_BITS;
		div_in.acc_y = QUO_W'(magy[COORD_BITS-1:0]) << FRAC_BITS;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			dax_s1    <= DIFF_W'(in_data.a_end_x) - DIFF_W'(in_data.a_start_x);
			day_s1    <= DIFF_W'(in_data.a_end_y) - DIFF_W'(in_data.a_start_y);
			dbx_s1    <= DIFF_W'(in_data.b_end_x) - DIFF_W'(in_data.b_start_x);
			dby_s1    <= DIFF_W'(in_data.b_end_y) - DIFF_W'(in_data.b_start_y);
			ox_s1     <= DIFF_W'(in_data.a_start_x) - DIFF_W'(in_data.b_start_x);
			oy_s1     <= DIFF_W'(in_data.a_start_y) - DIFF_W'(in_data.b_start_y);
			ex_s1     <= DIFF_W'(in_data.a_start_x) - DIFF_W'(in_data.b_end_x);
			ey_s1     <= DIFF_W'(in_data.a_start_y) - DIFF_W'(in_data.b_end_y);
			ax0_s1    <= in_data.a_start_x;
			ay0_s1    <= in_data.a_start_y;
			shared_s1 <= shared;

			den1_s2   <= PROD_W'(dby_s1) * PROD_W'(dax_s1);
			den2_s2   <= PROD_W'(dbx_s1) * PROD_W'(day_s1);
			na1_s2    <= PROD_W'(dbx_s1) * PROD_W'(oy_s1);
			na2_s2    <= PROD_W'(dby_s1) * PROD_W'(ox_s1);
			nb1_s2    <= PROD_W'(dax_s1) * PROD_W'(oy_s1);
			nb2_s2    <= PROD_W'(day_s1) * PROD_W'(ox_s1);
			sox_s2    <= PROD_W'(ox_s1) * PROD_W'(ox_s1);
			soy_s2    <= PROD_W'(oy_s1) * PROD_W'(oy_s1);
			sex_s2    <= PROD_W'(ex_s1) * PROD_W'(ex_s1);
			sey_s2    <= PROD_W'(ey_s1) * PROD_W'(ey_s1);
			sax_s2    <= PROD_W'(dax_s1) * PROD_W'(dax_s1);
			say_s2    <= PROD_W'(day_s1) * PROD_W'(day_s1);
			sbx_s2    <= PROD_W'(dbx_s1) * PROD_W'(dbx_s1);
			sby_s2    <= PROD_W'(dby_s1) * PROD_W'(dby_s1);
			dax_s2    <= dax_s1;
			day_s2    <= day_s1;
			ax0_s2    <= ax0_s1;
			ay0_s2    <= ay0_s1;
			shared_s2 <= shared_s1;

			den_s3    <= WIDE_W'(den1_s2) - WIDE_W'(den2_s2);
			na_s3     <= WIDE_W'(na1_s2) - WIDE_W'(na2_s2);
			nb_s3     <= WIDE_W'(nb1_s2) - WIDE_W'(nb2_s2);
			d1_s3     <= WIDE_W'(sox_s2) + WIDE_W'(soy_s2);
			d2_s3     <= WIDE_W'(sex_s2) + WIDE_W'(sey_s2);
			la_s3     <= WIDE_W'(sax_s2) + WIDE_W'(say_s2);
			lb_s3     <= WIDE_W'(sbx_s2) + WIDE_W'(sby_s2);
			dax_s3    <= dax_s2;
			day_s3    <= day_s2;
			ax0_s3    <= ax0_s2;
			ay0_s3    <= ay0_s2;
			shared_s3 <= shared_s2;

			side_s4   <= side;
			den_s4    <= den_a[PROD_W-1:0];
			na_s4     <= na_a[PROD_W-1:0];
			dxm_s4    <= dax_a[COORD_BITS-1:0];
			dym_s4    <= day_a[COORD_BITS-1:0];

			side_s5   <= side_s4;
			den_s5    <= den_s4;
			px_lo_s5  <= (COORD_BITS + HALF_W)'(dxm_s4) *
				(COORD_BITS + HALF_W)'(na_s4[HALF_W-1:0]);
			px_hi_s5  <= (COORD_BITS + PROD_W - HALF_W)'(dxm_s4) *
				(COORD_BITS + PROD_W - HALF_W)'(na_s4[PROD_W-1:HALF_W]);
			py_lo_s5  <= (COORD_BITS + HALF_W)'(dym_s4) *
				(COORD_BITS + HALF_W)'(na_s4[HALF_W-1:0]);
			py_hi_s5  <= (COORD_BITS + PROD_W - HALF_W)'(dym_s4) *
				(COORD_BITS + PROD_W - HALF_W)'(na_s4[PROD_W-1:HALF_W]);

			cell_s6   <= div_in;
		end
	end

	assign out_valid = v_s6;
	assign out_data  = cell_s6;

endmodule

`default_nettype wire

### hdl/segment_pair_intersection.sv
// Top level: front stages, a chain of divider cells, rounding and the output skid.
//
//   channel  signals                         direction  carries
//   pair     pair_valid, pair_ready, pair    in         two segments, pair_t
//   isect    isect_valid, isect_ready, isect out        flags and point, isect_t
//
// Takes one item every cycle while the skid is empty; an item passes 6 front
// stages, one cell per quotient bit (COORD_BITS + FRAC_BITS, 24 by default)
// and the output register. The divider chain does one restoring step per cell.
// Reset clears only the valid bits; there is no state between items.
// A stall on isect parks one item in the skid register; pair_ready then drops
// and the whole pipeline holds until the skid drains.
`default_nettype none

module segment_pair_intersection
	import spi_pkg::*;
(
	input  wire logic  clk,
	input  wire logic  arst_n,
	input  wire logic  pair_valid,
	output logic       pair_ready,
	input  wire pair_t pair,
	output logic       isect_valid,
	input  wire logic  isect_ready,
	output isect_t     isect
);

	logic   en;
	logic   chain_v [CELLS+1];
	cell_t  chain_d [CELLS+1];
	cell_t  last;
	isect_t fin;
	logic   push;
	logic   take;
	logic   out_v_q;
	logic   skid_v_q;
	isect_t out_q;
	isect_t skid_q;

	// truncate toward zero the value p0 + sign * quo/den in fixed point, then clamp
	function automatic logic signed [CROSS_BITS-1:0] fix_point(
		input logic signed [COORD_BITS-1:0] p0,
		input logic                         neg,
		input logic [QUO_W-1:0]             quo,
		input logic                         rem_nz
	);
		logic signed [SAT_W-1:0] base;
		logic signed [SAT_W-1:0] q;
		logic signed [SAT_W-1:0] s;
		logic signed [SAT_W-1:0] r;
		base = SAT_W'(p0) <<< FRAC_BITS;
		q    = SAT_W'(quo);
		if (!neg) begin
			s = base + q;
			r = (s < 0 && rem_nz) ? s + SAT_W'(1) : s;
		end else begin
			s = base - q;
			r = (s > 0 && rem_nz) ? s - SAT_W'(1) : s;
		end
		if (r > CROSS_MAX) begin
			r = CROSS_MAX;
		end else if (r < CROSS_MIN) begin
			r = CROSS_MIN;
		end
		return r[CROSS_BITS-1:0];
	endfunction

	// the pipeline moves whenever the skid is empty
	assign en         = !skid_v_q;
	assign pair_ready = en;

	spi_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (pair_valid),
		.in_data   (pair),
		.out_valid (chain_v[0]),
		.out_data  (chain_d[0])
	);

	for (genvar g = 0; g < CELLS; g++) begin : g_cell
		spi_div_cell u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.en        (en),
			.in_valid  (chain_v[g]),
			.in_data   (chain_d[g]),
			.out_valid (chain_v[g+1]),
			.out_data  (chain_d[g+1])
		);
	end

	assign last = chain_d[CELLS];

	// assemble the result item; drop the point when there is no proper crossing
	always_comb begin
		fin.hit         = last.side.hit;
		fin.strict_hit  = last.side.strict_hit;
		fin.same_line   = last.side.same_line;
		fin.overlap     = last.side.overlap;
		fin.point_valid = last.side.point_valid;
		if (last.side.point_valid) begin
			fin.cross_x = fix_point(last.side.base_x, last.side.neg_x, last.acc_x,
				last.rem_x != '0);
			fin.cross_y = fix_point(last.side.base_y, last.side.neg_y, last.acc_y,
				last.rem_y != '0);
		end else begin
			fin.cross_x = '0;
			fin.cross_y = '0;
		end
	end

	assign push = chain_v[CELLS] && en;
	assign take = out_v_q && isect_ready;

	// output register plus one skid entry: hold on stall, advance on take
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q  <= 1'b0;
			skid_v_q <= 1'b0;
		end else if (skid_v_q) begin
			if (take) begin
				skid_v_q <= 1'b0;
			end
		end else if (push) begin
			if (!out_v_q || take) begin
				out_v_q <= 1'b1;
			end else begin
				skid_v_q <= 1'b1;
			end
		end else if (take) begin
			out_v_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (skid_v_q) begin
			if (take) begin
				out_q <= skid_q;
			end
		end else if (push) begin
			if (!out_v_q || take) begin
				out_q <= fin;
			end else begin
				skid_q <= fin;
			end
		end
	end

	assign isect_valid = out_v_q;
	assign isect       = out_q;

	a_skid_needs_out: assert property (@(posedge clk) disable iff (!arst_n)
		skid_v_q |-> out_v_q)
		else $error("skid entry held with empty output register");

	a_skid_on_stall: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(skid_v_q) |-> $past(out_v_q && !isect_ready))
		else $error("skid filled without a stalled output");

	a_strict_in_hit: assert property (@(posedge clk) disable iff (!arst_n)
		isect_valid && (isect.strict_hit || isect.point_valid || isect.same_line)
			|-> isect.hit)
		else $error("hit missing on a result item");

	a_line_no_point: assert property (@(posedge clk) disable iff (!arst_n)
		isect_valid && isect.same_line |-> !isect.point_valid && isect.cross_x == '0
			&& isect.cross_y == '0)
		else $error("collinear item carries a crossing point");

	a_overlap_line: assert property (@(posedge clk) disable iff (!arst_n)
		isect_valid && isect.overlap |-> isect.same_line)
		else $error("overlap without collinear segments");

endmodule

`default_nettype wire

### sim/tb_segment_pair_intersection.sv
// Testbench for segment_pair_intersection: directed table and random pairs against a predictor.
`default_nettype none

module tb_segment_pair_intersection;
	import spi_pkg::*;

	localparam int N_RANDOM   = 1530;
	localparam int IDLE_LIMIT = 20000;
	localparam int DRAIN_WAIT = 64;

	// one directed row: the pair, whether the result is typed in, and that result
	typedef struct {
		pair_t  stim;
		bit     fixed;
		isect_t want;
	} row_t;

	logic   clk = 1'b0;
	logic   arst_n = 1'b0;
	logic   pair_valid = 1'b0;
	logic   pair_ready;
	pair_t  pair = '0;
	logic   isect_valid;
	logic   isect_ready = 1'b0;
	isect_t isect;

	isect_t expected_q[$];
	int     mismatches = 0;
	int     idle_cycles = 0;
	int     pairs_sent = 0;
	int     results_seen = 0;
	int     hits_seen = 0;
	int     collinear_seen = 0;
	int     overlap_seen = 0;
	int     strict_miss_seen = 0;
	bit     stall_mode = 1'b0;
	int     stall_phase = 0;
	row_t   rows[$];

	segment_pair_intersection u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.pair_valid(pair_valid),
		.pair_ready(pair_ready),
		.pair(pair),
		.isect_valid(isect_valid),
		.isect_ready(isect_ready),
		.isect(isect)
	);

	always #2 clk = ~clk;

	// Truncate (p0 + d*num/den) * 2^FRAC_BITS toward zero; den > 0.
	function automatic longint fixed_coord(longint p0, longint d, longint num, longint den);
		longint numer;
		longint q;
		numer = (p0 * den + d * num) * (64'sd1 <<< FRAC_BITS);
		q = numer / den;   // SystemVerilog division truncates toward zero
		return q;
	endfunction

	function automatic logic [CROSS_BITS-1:0] clamp_cross(longint v);
		longint hi;
		hi = (64'sd1 <<< (CROSS_BITS - 1)) - 1;
		if (v > hi) v = hi;
		if (v < -hi - 1) v = -hi - 1;
		return v[CROSS_BITS-1:0];
	endfunction

	function automatic longint dist2(longint x, longint y);
		return x * x + y * y;
	endfunction

	// Predict the intersection result of one segment pair.
	function automatic isect_t intersect_pair(pair_t p);
		longint ax0, ay0, ax1, ay1, bx0, by0, bx1, by1;
		longint dax, day, dbx, dby, ox, oy, den, na, nb;
		longint d1, d2, la, lb;
		bit     shared;
		isect_t r;
		ax0 = p.a_start_x; ay0 = p.a_start_y; ax1 = p.a_end_x; ay1 = p.a_end_y;
		bx0 = p.b_start_x; by0 = p.b_start_y; bx1 = p.b_end_x; by1 = p.b_end_y;
		dax = ax1 - ax0; day = ay1 - ay0;
		dbx = bx1 - bx0; dby = by1 - by0;
		ox = ax0 - bx0; oy = ay0 - by0;
		den = dby * dax - dbx * day;
		na = dbx * oy - dby * ox;
		nb = dax * oy - day * ox;
		r = '0;
		if (den == 0) begin
			if (na == 0 && nb == 0) begin
				d1 = dist2(ox, oy);
				d2 = dist2(ax0 - bx1, ay0 - by1);
				la = dist2(dax, day);
				lb = dist2(dbx, dby);
				r.hit = 1'b1;
				r.strict_hit = 1'b1;
				r.same_line = 1'b1;
				r.overlap = (d1 == lb || d1 == la || d2 == la || d2 == lb);
			end
		end else begin
			if (den < 0) begin
				den = -den; na = -na; nb = -nb;
			end
			if (na >= 0 && na <= den && nb >= 0 && nb <= den) begin
				shared = (ax0 == bx0 && ay0 == by0) || (ax0 == bx1 && ay0 == by1) ||
					(ax1 == bx0 && ay1 == by0) || (ax1 == bx1 && ay1 == by1);
				r.hit = 1'b1;
				r.strict_hit = !shared;
				r.point_valid = 1'b1;
				r.cross_x = clamp_cross(fixed_coord(ax0, dax, na, den));
				r.cross_y = clamp_cross(fixed_coord(ay0, day, na, den));
			end
		end
		return r;
	endfunction

	function automatic pair_t make_pair(int ax0, int ay0, int ax1, int ay1,
			int bx0, int by0, int bx1, int by1);
		pair_t p;
		p.a_start_x = COORD_BITS'(ax0); p.a_start_y = COORD_BITS'(ay0);
		p.a_end_x = COORD_BITS'(ax1); p.a_end_y = COORD_BITS'(ay1);
		p.b_start_x = COORD_BITS'(bx0); p.b_start_y = COORD_BITS'(by0);
		p.b_end_x = COORD_BITS'(bx1); p.b_end_y = COORD_BITS'(by1);
		return p;
	endfunction

	function automatic isect_t make_result(bit h, bit s, bit sl, bit ov, bit pv,
			int cx, int cy);
		isect_t r;
		r.hit = h; r.strict_hit = s; r.same_line = sl; r.overlap = ov;
		r.point_valid = pv; r.cross_x = CROSS_BITS'(cx); r.cross_y = CROSS_BITS'(cy);
		return r;
	endfunction

	function automatic int coord(int lo, int hi);
		return lo + int'($urandom_range(hi - lo));
	endfunction

	// Random pair: mostly small boxes so hits, collinear and shared ends turn up often.
	function automatic pair_t random_pair();
		int     kind, span, ax0, ay0, ax1, ay1, t, u, k;
		pair_t  p;
		kind = $urandom_range(9);
		span = ($urandom_range(3) == 0) ? 32767 : (($urandom_range(1) == 0) ? 8 : 300);
		ax0 = coord(-span - 1, span); ay0 = coord(-span - 1, span);
		ax1 = coord(-span - 1, span); ay1 = coord(-span - 1, span);
		p = make_pair(ax0, ay0, ax1, ay1, coord(-span - 1, span), coord(-span - 1, span),
			coord(-span - 1, span), coord(-span - 1, span));
		case (kind)
			0: begin
				p = {$urandom(), $urandom(), $urandom(), $urandom()};
			end
			1, 2: begin
				// collinear: B on the line of A at multiples of a small step
				t = coord(-4, 4); u = coord(-4, 4); k = coord(-3, 3);
				p.a_end_x = COORD_BITS'(ax0 + 2 * t); p.a_end_y = COORD_BITS'(ay0 + 2 * u);
				p.b_start_x = COORD_BITS'(ax0 + k * t); p.b_start_y = COORD_BITS'(ay0 + k * u);
				k = coord(-3, 3);
				p.b_end_x = COORD_BITS'(ax0 + k * t); p.b_end_y = COORD_BITS'(ay0 + k * u);
			end
			3: begin
				// parallel: B is A shifted sideways
				t = coord(-50, 50);
				p.b_start_x = COORD_BITS'(ax0 + t); p.b_start_y = COORD_BITS'(ay0 - 1);
				p.b_end_x = COORD_BITS'(ax1 + t); p.b_end_y = COORD_BITS'(ay1 - 1);
			end
			4: begin
				// shared endpoint
				if ($urandom_range(1)) begin
					p.b_start_x = p.a_end_x; p.b_start_y = p.a_end_y;
				end else begin
					p.b_end_x = p.a_start_x; p.b_end_y = p.a_start_y;
				end
			end
			5, 6: begin
				// crossing through the midpoint of A
				t = (ax0 + ax1) / 2; u = (ay0 + ay1) / 2;
				p.b_end_x = COORD_BITS'(2 * t - int'(p.b_start_x));
				p.b_end_y = COORD_BITS'(2 * u - int'(p.b_start_y));
				if (p.b_end_x != 2 * t - int'(p.b_start_x)) p.b_end_x = COORD_BITS'(t);
			end
			default: ;
		endcase
		return p;
	endfunction

	task automatic report_mismatch(string what, longint got, longint want);
		$display("mismatch %0s at result %0d: got %0d, want %0d",
			what, results_seen, got, want);
		mismatches++;
	endtask

	// Hand one pair to the block: hold valid and payload until accepted.
	task automatic send_pair(pair_t p, bit fixed, isect_t want);
		pair_valid <= 1'b1;
		pair <= p;
		do
			@(posedge clk);
		while (!pair_ready);
		expected_q.push_back(fixed ? want : intersect_pair(p));
		pairs_sent++;
	endtask

	task automatic drop_valid();
		pair_valid <= 1'b0;
		pair <= {$urandom(), $urandom(), $urandom(), $urandom()};
	endtask

	// Receiver: accept and check items; ready follows a changing stall pattern.
	always @(posedge clk) begin
		isect_t want;
		if (arst_n && isect_valid && isect_ready) begin
			if (expected_q.size() == 0) begin
				report_mismatch("unexpected item", 1, 0);
			end else begin
				want = expected_q.pop_front();
				if (isect.hit !== want.hit) report_mismatch("hit", isect.hit, want.hit);
				if (isect.strict_hit !== want.strict_hit)
					report_mismatch("strict_hit", isect.strict_hit, want.strict_hit);
				if (isect.same_line !== want.same_line)
					report_mismatch("same_line", isect.same_line, want.same_line);
				if (isect.overlap !== want.overlap)
					report_mismatch("overlap", isect.overlap, want.overlap);
				if (isect.point_valid !== want.point_valid)
					report_mismatch("point_valid", isect.point_valid, want.point_valid);
				if (isect.cross_x !== want.cross_x)
					report_mismatch("cross_x", isect.cross_x, want.cross_x);
				if (isect.cross_y !== want.cross_y)
					report_mismatch("cross_y", isect.cross_y, want.cross_y);
				hits_seen += want.hit;
				collinear_seen += want.same_line;
				overlap_seen += want.overlap;
				strict_miss_seen += (want.point_valid && !want.strict_hit);
			end
			results_seen++;
		end
		// switch between free flow and stalling now and then
		if ($urandom_range(63) == 0) stall_mode <= !stall_mode;
		stall_phase <= stall_phase + 1;
		if (!arst_n)
			isect_ready <= 1'b0;
		else if (!stall_mode)
			isect_ready <= 1'b1;
		else
			isect_ready <= (stall_phase % 5 < 2) ? 1'b0 : ($urandom_range(3) != 0);
	end

	// Watchdog: stop when nothing moves for too long.
	always @(posedge clk) begin
		if ((pair_valid && pair_ready) || (isect_valid && isect_ready) || !arst_n)
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("watchdog: nothing accepted for %0d cycles", IDLE_LIMIT);
			$display("TEST FAILED");
			$finish;
		end
	end

	initial begin
		int burst;
		// directed rows: typed results only where they are plain to read
		rows.push_back('{make_pair(0, 0, 0, 0, 0, 0, 0, 0), 1, make_result(1, 1, 1, 1, 0, 0, 0)});
		rows.push_back('{make_pair(0, 0, 4, 4, 0, 4, 4, 0), 1,
			make_result(1, 1, 0, 0, 1, 512, 512)});
		rows.push_back('{make_pair(0, 0, 4, 0, 0, 1, 4, 1), 1, make_result(0, 0, 0, 0, 0, 0, 0)});
		rows.push_back('{make_pair(0, 0, 4, 0, 2, 0, 6, 0), 1, make_result(1, 1, 1, 0, 0, 0, 0)});
		rows.push_back('{make_pair(0, 0, 4, 0, 5, 0, 9, 0), 1, make_result(1, 1, 1, 0, 0, 0, 0)});
		rows.push_back('{make_pair(0, 0, 4, 4, 4, 4, 8, 0), 1,
			make_result(1, 0, 0, 0, 1, 1024, 1024)});
		rows.push_back('{make_pair(0, 0, 1, 1, 5, 0, 6, 2), 1, make_result(0, 0, 0, 0, 0, 0, 0)});
		rows.push_back('{make_pair(-32768, -32768, 32767, 32767, -32768, 32767, 32767, -32768),
			0, '0});
		rows.push_back('{make_pair(32767, 32767, -32768, -32768, 32767, -32768, -32768, 32767),
			0, '0});
		rows.push_back('{make_pair(-32768, 0, 32767, 0, 0, -32768, 0, 32767), 1,
			make_result(1, 1, 0, 0, 1, 0, 0)});
		rows.push_back('{make_pair(-32768, -32768, -32768, 32767, -32768, -32768, 32767, -32768),
			1, make_result(1, 0, 0, 0, 1, -8388608, -8388608)});
		rows.push_back('{make_pair(32767, 32767, 32767, -32768, 32767, 32767, -32768, 32767),
			1, make_result(1, 0, 0, 0, 1, 8388352, 8388352)});
		rows.push_back('{make_pair(0, 0, 3, 1, 0, 1, 3, 0), 0, '0});
		rows.push_back('{make_pair(0, 0, 3, 0, 1, -1, 2, 2), 0, '0});
		rows.push_back('{make_pair(0, 0, -3, 1, 0, 1, -3, 0), 0, '0});
		rows.push_back('{make_pair(5, 5, 5, 5, 0, 0, 10, 10), 1, make_result(1, 1, 1, 0, 0, 0, 0)});
		rows.push_back('{make_pair(5, 5, 5, 5, 0, 1, 10, 11), 1, make_result(0, 0, 0, 0, 0, 0, 0)});
		rows.push_back('{make_pair(-1, -1, -1, -1, -1, -1, -1, -1), 1,
			make_result(1, 1, 1, 1, 0, 0, 0)});
		rows.push_back('{make_pair(0, 0, 2, 0, 2, 0, 2, 5), 1, make_result(1, 0, 0, 0, 1, 512, 0)});
		rows.push_back('{make_pair(32767, -32768, -32768, 32767, 0, 0, -1, -1), 0, '0});

		// hold reset, then release it once
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed part
		foreach (rows[i]) send_pair(rows[i].stim, rows[i].fixed, rows[i].want);
		drop_valid();

		// hold off until every directed item is back
		while (expected_q.size() != 0) @(posedge clk);

		// random part in bursts with gaps; some bursts run gap-free
		while (pairs_sent < rows.size() + N_RANDOM) begin
			burst = $urandom_range(1, 40);
			repeat (burst) send_pair(random_pair(), 0, '0);
			if ($urandom_range(3) != 0) begin
				drop_valid();
				repeat ($urandom_range(1, 12)) @(posedge clk);
			end
			if ($urandom_range(40) == 0) begin
				drop_valid();
				while (expected_q.size() != 0) @(posedge clk);
			end
		end
		drop_valid();

		while (expected_q.size() != 0) @(posedge clk);
		repeat (DRAIN_WAIT) @(posedge clk);

		$display("covered %0d pairs: %0d hits, %0d collinear, %0d overlapping,",
			pairs_sent, hits_seen, collinear_seen, overlap_seen);
		$display("%0d crossings at a shared endpoint, with random stalls on both sides",
			strict_miss_seen);
		if (mismatches == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule

`default_nettype wire

### filelist.f
hdl/spi_pkg.sv
hdl/spi_div_cell.sv
hdl/spi_front.sv
hdl/segment_pair_intersection.sv
sim/tb_segment_pair_intersection.sv
